@@ src/cvd_pkg.sv @@
// ----------------------------------------------------------------------------
// cvd_pkg
// Shared widths and constants of the cube vertex unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cvd_pkg;

  localparam int unsigned CVD_COORD_WIDTH = 32;

  // The diagonal is normalized so its largest component lies in [2^28, 2^29).
  localparam int unsigned NORM_LO = 28;
  localparam int unsigned KQ      = 28;
  localparam int unsigned TW      = 30;  // normalized component, signed
  localparam int unsigned SQ_XW   = 60;  // radicand width
  localparam int unsigned SQW     = 30;  // root width
  localparam int unsigned NW      = 62;  // numerator / Q28 sum width, signed
  localparam int unsigned QW      = 32;  // quotient width, signed
  localparam int unsigned JW      = 6;   // final shift amount
  localparam int unsigned KW      = 30;  // Q28 constant width, signed

  localparam logic signed [KW-1:0] K_THIRD = KW'(89478485);
  localparam logic signed [KW-1:0] K_R2_3  = KW'(126541687);
  localparam logic signed [KW-1:0] K_2R2_3 = KW'(253083375);
  localparam logic signed [KW-1:0] K_R23   = KW'(219176632);

  localparam int unsigned VIDX_W = 3;

  typedef enum logic [VIDX_W-1:0] {
    VTX_PU  = 3'd0,
    VTX_PV  = 3'd1,
    VTX_PVV = 3'd2,
    VTX_PUU = 3'd3,
    VTX_MVV = 3'd4,
    VTX_MUU = 3'd5,
    VTX_MU  = 3'd6,
    VTX_MV  = 3'd7
  } vtx_e;

endpackage

`default_nettype wire

@@ src/cvd_if.sv @@
// ----------------------------------------------------------------------------
// cvd_if
// Diagonal input channel and corner output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cvd_in_if #(
  parameter int unsigned COORD_WIDTH = cvd_pkg::CVD_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] corner_a_x;
  logic signed [COORD_WIDTH-1:0] corner_a_y;
  logic signed [COORD_WIDTH-1:0] corner_a_z;
  logic signed [COORD_WIDTH-1:0] corner_b_x;
  logic signed [COORD_WIDTH-1:0] corner_b_y;
  logic signed [COORD_WIDTH-1:0] corner_b_z;

  modport source (output valid, corner_a_x, corner_a_y, corner_a_z,
                  corner_b_x, corner_b_y, corner_b_z, input ready);
  modport sink   (input valid, corner_a_x, corner_a_y, corner_a_z,
                  corner_b_x, corner_b_y, corner_b_z, output ready);
endinterface

interface cvd_out_if #(
  parameter int unsigned COORD_WIDTH = cvd_pkg::CVD_COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    vertex_index;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic signed [COORD_WIDTH-1:0] vertex_z;
  logic                          last_vertex;
  logic                          degenerate;

  modport source (output valid, vertex_index, vertex_x, vertex_y, vertex_z,
                  last_vertex, degenerate, input ready);
  modport sink   (input valid, vertex_index, vertex_x, vertex_y, vertex_z,
                  last_vertex, degenerate, output ready);
endinterface

`default_nettype wire

@@ src/cvd_isqrt.sv @@
// ----------------------------------------------------------------------------
// cvd_isqrt
// Pipelined rounded integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvd_isqrt #(
  parameter int unsigned LANES = 2,
  parameter int unsigned XW    = cvd_pkg::SQ_XW,
  parameter int unsigned RW    = cvd_pkg::SQW,
  parameter int unsigned SW    = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i [LANES],
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] root_o [LANES],
  output logic [SW-1:0] side_o
);

  localparam int unsigned STEPS = XW / 2;

  logic [XW-1:0]    rem_q [STEPS][LANES];
  logic [XW-1:0]    res_q [STEPS][LANES];
  logic [XW-1:0]    rem_d [STEPS][LANES];
  logic [XW-1:0]    res_d [STEPS][LANES];
  logic [SW-1:0]    side_q [STEPS];
  logic [STEPS-1:0] v_q;
  logic [RW-1:0]    root_q [LANES];
  logic [SW-1:0]    sidef_q;
  logic             vf_q;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [XW:0] BIT = (XW+1)'(1) << (XW - 2 - 2*k);
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [XW-1:0] rem_in;
      logic [XW-1:0] res_in;
      logic [XW:0]   trial;
      if (k == 0) begin : g_first
        assign rem_in = x_i[l];
        assign res_in = '0;
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign res_in = res_q[k-1][l];
      end
      assign trial = {1'b0, res_in} + BIT;
      always_comb begin
        if ({1'b0, rem_in} >= trial) begin
          rem_d[k][l] = XW'({1'b0, rem_in} - trial);
          res_d[k][l] = XW'(({1'b0, res_in} >> 1) + BIT);
        end else begin
          rem_d[k][l] = rem_in;
          res_d[k][l] = res_in >> 1;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= rem_d[k][l];
          res_q[k][l] <= res_d[k][l];
        end
      end
    end
    if (k == 0) begin : g_side0
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_i;
      end
    end else begin : g_siden
      always_ff @(posedge clk_i) begin
        if (en_i) side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[STEPS-2:0], valid_i};
      vf_q <= v_q[STEPS-1];
    end
  end

  // round to nearest: bump when the remainder exceeds the floor root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        root_q[l] <= RW'(res_q[STEPS-1][l])
                   + RW'(rem_q[STEPS-1][l] > res_q[STEPS-1][l]);
      end
      sidef_q <= side_q[STEPS-1];
    end
  end

  assign valid_o = vf_q;
  assign root_o  = root_q;
  assign side_o  = sidef_q;

endmodule

`default_nettype wire

@@ src/cvd_div.sv @@
// ----------------------------------------------------------------------------
// cvd_div
// Pipelined signed division by a shared positive divisor, rounding half
// away from zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvd_div #(
  parameter int unsigned LANES = 6,
  parameter int unsigned NW    = cvd_pkg::NW,
  parameter int unsigned DENW  = cvd_pkg::SQW,
  parameter int unsigned QW    = cvd_pkg::QW,
  parameter int unsigned SW    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i [LANES],
  input  logic [DENW-1:0]      den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [QW-1:0] quo_o [LANES],
  output logic [SW-1:0]        side_o
);

  localparam int unsigned CMPW = ((NW > DENW + QW) ? NW : DENW + QW) + 1;

  logic [NW-1:0]   rem_q [QW+1][LANES];
  logic [QW-1:0]   quo_q [QW+1][LANES];
  logic            neg_q [QW+1][LANES];
  logic [DENW-1:0] den_q [QW+1];
  logic [SW-1:0]   side_q [QW+1];
  logic [QW:0]     v_q;
  logic signed [QW-1:0] out_q [LANES];
  logic [SW-1:0]   sidef_q;
  logic            vf_q;

  // magnitude plus half the divisor gives the rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= (num_i[l][NW-1] ? NW'(-num_i[l]) : NW'(num_i[l]))
                     + NW'(den_i >> 1);
        quo_q[0][l] <= '0;
        neg_q[0][l] <= num_i[l][NW-1];
      end
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int unsigned SH = QW - k;
    logic [CMPW-1:0] dsh;
    assign dsh = CMPW'(den_q[k-1]) << SH;
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic fits;
      assign fits = CMPW'(rem_q[k-1][l]) >= dsh;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= fits ? NW'(CMPW'(rem_q[k-1][l]) - dsh) : rem_q[k-1][l];
          quo_q[k][l] <= quo_q[k-1][l] | (fits ? (QW'(1) << SH) : '0);
          neg_q[k][l] <= neg_q[k-1][l];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[QW-1:0], valid_i};
      vf_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < LANES; l++) begin
        out_q[l] <= neg_q[QW][l] ? -$signed(quo_q[QW][l]) : $signed(quo_q[QW][l]);
      end
      sidef_q <= side_q[QW];
    end
  end

  assign valid_o = vf_q;
  assign quo_o   = out_q;
  assign side_o  = sidef_q;

endmodule

`default_nettype wire

@@ src/cvd_emit.sv @@
// ----------------------------------------------------------------------------
// cvd_emit
// Holds one finished diagonal and sends its eight corners in index order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvd_emit #(
  parameter int unsigned COORD_WIDTH = cvd_pkg::CVD_COORD_WIDTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH:0]   sum_i [3],
  input  logic signed [COORD_WIDTH:0]   dif_i [3],
  input  logic signed [COORD_WIDTH+3:0] ov_i [3],
  input  logic signed [COORD_WIDTH+3:0] ou_i [3],
  input  logic signed [COORD_WIDTH+3:0] ow_i [3],
  input  logic                          deg_i,
  output logic                          take_o,
  cvd_out_if.source                     vert_o
);
  import cvd_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned OW = COORD_WIDTH + 4;

  logic                 busy_q;
  vtx_e                 k_q;
  logic signed [DW-1:0] sum_q [3];
  logic signed [OW-1:0] ou_q [3], ov_q [3], ow_q [3], od_q [3];
  logic                 deg_q;
  logic signed [OW-1:0] off [3];
  logic signed [OW:0]   tot [3];
  logic signed [OW:0]   half [3];
  logic signed [COORD_WIDTH-1:0] crd [3];

  assign take_o = !busy_q || (vert_o.ready && k_q == VTX_MV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= VTX_PU;
    end else if (take_o) begin
      busy_q <= valid_i;
      k_q    <= VTX_PU;
    end else if (vert_o.ready) begin
      k_q    <= vtx_e'(k_q + 3'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && valid_i) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= sum_i[i];
        od_q[i]  <= OW'(dif_i[i]);
        ov_q[i]  <= ov_i[i];
        ou_q[i]  <= ou_i[i];
        ow_q[i]  <= ow_i[i];
      end
      deg_q <= deg_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (k_q)
        VTX_PU:  off[i] = od_q[i];
        VTX_PV:  off[i] = ov_q[i];
        VTX_PVV: off[i] = ow_q[i];
        VTX_PUU: off[i] = ou_q[i];
        VTX_MVV: off[i] = -ow_q[i];
        VTX_MUU: off[i] = -ou_q[i];
        VTX_MU:  off[i] = -od_q[i];
        VTX_MV:  off[i] = -ov_q[i];
        default: off[i] = '0;
      endcase
      tot[i]  = (OW+1)'(sum_q[i]) + (OW+1)'(off[i]) + (OW+1)'(1);
      half[i] = tot[i] >>> 1;
      // saturate when the bits above the coordinate are not a sign extension
      if (half[i][OW:COORD_WIDTH-1] != '0 && half[i][OW:COORD_WIDTH-1] != '1) begin
        crd[i] = half[i][OW] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                             : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
        crd[i] = half[i][COORD_WIDTH-1:0];
      end
    end
  end

  assign vert_o.valid        = busy_q;
  assign vert_o.vertex_index = k_q;
  assign vert_o.vertex_x     = crd[0];
  assign vert_o.vertex_y     = crd[1];
  assign vert_o.vertex_z     = crd[2];
  assign vert_o.last_vertex  = (k_q == VTX_MV);
  assign vert_o.degenerate   = deg_q;

endmodule

`default_nettype wire

@@ src/cube_vertices_from_diagonal_unit.sv @@
// ----------------------------------------------------------------------------
// cube_vertices_from_diagonal_unit
// Eight cube corners from the two ends of a body diagonal, fixed point.
//
//   channel  | dir | transfer carries
//   ---------+-----+-------------------------------------------------
//   diag_i   | in  | corner_a_x/y/z, corner_b_x/y/z
//   vert_o   | out | vertex_index, vertex_x/y/z, last_vertex, degenerate
//
// Each diagonal gives eight corner transfers, one per cycle while vert_o is
// ready; in steady state a diagonal is taken only as the last corner of the
// one before goes out; the single corner port sets that rate. The wait for the
// first corner is dominated by the bit-serial square root and divider
// pipelines. Reset clears only the valid bits and the corner index.
// A stall on vert_o freezes the whole pipeline once its last stage is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cube_vertices_from_diagonal_unit #(
  parameter int unsigned COORD_WIDTH = cvd_pkg::CVD_COORD_WIDTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cvd_in_if.sink    diag_i,
  cvd_out_if.source vert_o
);
  import cvd_pkg::*;

  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = $clog2(DW);
  localparam int unsigned OW  = COORD_WIDTH + 4;
  localparam int unsigned PRW = 2 * TW;
  localparam int unsigned SSW = 6*TW + 3*NW + 6*DW + JW + 1;
  localparam int unsigned VSW = 3*TW + 6*DW + JW + 1;

  logic en, take;

  // S1: sum, difference and its magnitude
  logic signed [COORD_WIDTH-1:0] a_in [3], b_in [3];
  logic v1_q;
  logic signed [DW-1:0] s1_q [3], d1_q [3];
  logic [DW-1:0] m1_q [3];

  assign a_in[0] = diag_i.corner_a_x;
  assign a_in[1] = diag_i.corner_a_y;
  assign a_in[2] = diag_i.corner_a_z;
  assign b_in[0] = diag_i.corner_b_x;
  assign b_in[1] = diag_i.corner_b_y;
  assign b_in[2] = diag_i.corner_b_z;
  assign diag_i.ready = en;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_q[i] <= DW'(a_in[i]) + DW'(b_in[i]);
        d1_q[i] <= DW'(a_in[i]) - DW'(b_in[i]);
        m1_q[i] <= (a_in[i] < b_in[i]) ? DW'(DW'(b_in[i]) - DW'(a_in[i]))
                                       : DW'(DW'(a_in[i]) - DW'(b_in[i]));
      end
    end
  end

  // S2: largest magnitude
  logic v2_q, deg2_q;
  logic signed [DW-1:0] s2_q [3], d2_q [3];
  logic [DW-1:0] m2_q [3], mx2_q, mx01;

  assign mx01 = (m1_q[0] > m1_q[1]) ? m1_q[0] : m1_q[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q   <= s1_q;
      d2_q   <= d1_q;
      m2_q   <= m1_q;
      mx2_q  <= (mx01 > m1_q[2]) ? mx01 : m1_q[2];
      deg2_q <= (m1_q[0] == '0) && (m1_q[1] == '0) && (m1_q[2] == '0);
    end
  end

  // S3: position of the leading one
  logic v3_q, deg3_q;
  logic signed [DW-1:0] s3_q [3], d3_q [3];
  logic [DW-1:0] m3_q [3];
  logic [PW-1:0] p3_d, p3_q;

  always_comb begin
    p3_d = '0;
    for (int i = 0; i < DW; i++) begin
      if (mx2_q[i]) p3_d = PW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q   <= s2_q;
      d3_q   <= d2_q;
      m3_q   <= m2_q;
      p3_q   <= p3_d;
      deg3_q <= deg2_q;
    end
  end

  // S4: normalize to [2^28, 2^29)
  logic v4_q, deg4_q;
  logic signed [DW-1:0] s4_q [3], d4_q [3];
  logic signed [TW-1:0] t4_d [3], t4_q [3];
  logic [JW-1:0] j4_q;

  always_comb begin
    logic [TW+DW-1:0]        wm;
    logic signed [TW+DW-1:0] ws;
    for (int i = 0; i < 3; i++) begin
      wm = (TW+DW)'(m3_q[i]);
      ws = (TW+DW)'(d3_q[i]);
      if (int'(p3_q) >= NORM_LO) begin
        wm = wm >> (int'(p3_q) - NORM_LO);
        t4_d[i] = d3_q[i][DW-1] ? -$signed(wm[TW-1:0]) : $signed(wm[TW-1:0]);
      end else begin
        ws = ws <<< (NORM_LO - int'(p3_q));
        t4_d[i] = ws[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q   <= s3_q;
      d4_q   <= d3_q;
      t4_q   <= t4_d;
      j4_q   <= JW'(KQ + NORM_LO - int'(p3_q));
      deg4_q <= deg3_q;
    end
  end

  // S5: squares and cross products
  logic v5_q, deg5_q;
  logic signed [DW-1:0]  s5_q [3], d5_q [3];
  logic signed [TW-1:0]  t5_q [3];
  logic [JW-1:0]         j5_q;
  logic signed [PRW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q   <= s4_q;
      d5_q   <= d4_q;
      t5_q   <= t4_q;
      j5_q   <= j4_q;
      deg5_q <= deg4_q;
      xx_q   <= t4_q[0] * t4_q[0];
      yy_q   <= t4_q[1] * t4_q[1];
      zz_q   <= t4_q[2] * t4_q[2];
      xy_q   <= t4_q[0] * t4_q[1];
      xz_q   <= t4_q[0] * t4_q[2];
      yz_q   <= t4_q[1] * t4_q[2];
    end
  end

  // S6: axis choice, radicands, numerators of m
  logic v6_q, deg6_q;
  logic signed [DW-1:0] s6_q [3], d6_q [3];
  logic signed [TW-1:0] t6_q [3], q6_d [3], q6_q [3];
  logic signed [NW-1:0] nm6_d [3], nm6_q [3];
  logic [JW-1:0]        j6_q;
  logic [SQ_XW-1:0]     q2_d, q2_q, r2_q, x2u, y2u, z2u;
  logic [63:0]          lhs, rhs;
  logic                 use_y;

  assign x2u = xx_q[SQ_XW-1:0];
  assign y2u = yy_q[SQ_XW-1:0];
  assign z2u = zz_q[SQ_XW-1:0];
  assign lhs = 64'(x2u) * 64'd7;
  assign rhs = (64'(y2u) + 64'(z2u)) * 64'd9;
  assign use_y = lhs > rhs;

  always_comb begin
    if (use_y) begin
      q2_d     = x2u + z2u;
      q6_d[0]  = -t5_q[2];
      q6_d[1]  = '0;
      q6_d[2]  = t5_q[0];
      nm6_d[0] = -NW'(xy_q);
      nm6_d[1] = NW'(q2_d);
      nm6_d[2] = -NW'(yz_q);
    end else begin
      q2_d     = y2u + z2u;
      q6_d[0]  = '0;
      q6_d[1]  = t5_q[2];
      q6_d[2]  = -t5_q[1];
      nm6_d[0] = NW'(q2_d);
      nm6_d[1] = -NW'(xy_q);
      nm6_d[2] = -NW'(xz_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q   <= s5_q;
      d6_q   <= d5_q;
      t6_q   <= t5_q;
      j6_q   <= j5_q;
      deg6_q <= deg5_q;
      q6_q   <= q6_d;
      nm6_q  <= nm6_d;
      q2_q   <= q2_d;
      r2_q   <= x2u + y2u + z2u;
    end
  end

  // square roots of q2 and r2
  logic [SQ_XW-1:0] sq_in [2];
  logic [SQW-1:0]   sq_out [2];
  logic [SSW-1:0]   sq_side_i, sq_side_o;
  logic             vs_o;

  assign sq_in[0] = q2_q;
  assign sq_in[1] = r2_q;
  assign sq_side_i = {t6_q[0], t6_q[1], t6_q[2], q6_q[0], q6_q[1], q6_q[2],
                      nm6_q[0], nm6_q[1], nm6_q[2], s6_q[0], s6_q[1], s6_q[2],
                      d6_q[0], d6_q[1], d6_q[2], j6_q, deg6_q};

  cvd_isqrt #(
    .LANES (2),
    .XW    (SQ_XW),
    .RW    (SQW),
    .SW    (SSW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .x_i     (sq_in),
    .side_i  (sq_side_i),
    .valid_o (vs_o),
    .root_o  (sq_out),
    .side_o  (sq_side_o)
  );

  logic signed [TW-1:0] ts_w [3], qs_w [3];
  logic signed [NW-1:0] nms_w [3];
  logic signed [DW-1:0] ss_w [3], ds_w [3];
  logic [JW-1:0]        js_w;
  logic                 degs_w;

  assign {ts_w[0], ts_w[1], ts_w[2], qs_w[0], qs_w[1], qs_w[2],
          nms_w[0], nms_w[1], nms_w[2], ss_w[0], ss_w[1], ss_w[2],
          ds_w[0], ds_w[1], ds_w[2], js_w, degs_w} = sq_side_o;

  // S7: clamp Q, numerators of rn
  logic v7_q, deg7_q;
  logic signed [DW-1:0] s7_q [3], d7_q [3];
  logic signed [TW-1:0] t7_q [3];
  logic signed [NW-1:0] nm7_q [6];
  logic [JW-1:0]        j7_q;
  logic [SQW-1:0]       qn7_q;
  logic signed [SQW+TW:0] rq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) rq[i] = $signed({1'b0, sq_out[1]}) * qs_w[i];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_q   <= ss_w;
      d7_q   <= ds_w;
      t7_q   <= ts_w;
      j7_q   <= js_w;
      deg7_q <= degs_w;
      qn7_q  <= (sq_out[0] == '0) ? SQW'(1) : sq_out[0];
      for (int i = 0; i < 3; i++) begin
        nm7_q[i]   <= nms_w[i];
        nm7_q[3+i] <= NW'(rq[i]);
      end
    end
  end

  // divisions by Q: m in lanes 0..2, rn in lanes 3..5
  logic signed [QW-1:0] quo [6];
  logic [VSW-1:0]       dv_side_i, dv_side_o;
  logic                 vd_o;

  assign dv_side_i = {t7_q[0], t7_q[1], t7_q[2], s7_q[0], s7_q[1], s7_q[2],
                      d7_q[0], d7_q[1], d7_q[2], j7_q, deg7_q};

  cvd_div #(
    .LANES (6),
    .NW    (NW),
    .DENW  (SQW),
    .QW    (QW),
    .SW    (VSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (nm7_q),
    .den_i   (qn7_q),
    .side_i  (dv_side_i),
    .valid_o (vd_o),
    .quo_o   (quo),
    .side_o  (dv_side_o)
  );

  logic signed [TW-1:0] td_w [3];
  logic signed [DW-1:0] sd_w [3], dd_w [3];
  logic [JW-1:0]        jd_w;
  logic                 degd_w;

  assign {td_w[0], td_w[1], td_w[2], sd_w[0], sd_w[1], sd_w[2],
          dd_w[0], dd_w[1], dd_w[2], jd_w, degd_w} = dv_side_o;

  // S8: Q28 products
  logic v8_q, deg8_q;
  logic signed [DW-1:0] s8_q [3], d8_q [3];
  logic [JW-1:0]        j8_q;
  logic signed [KW+TW-1:0] kt8_q [3];
  logic signed [KW+QW-1:0] k2m8_q [3], km8_q [3], kr8_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_q   <= sd_w;
      d8_q   <= dd_w;
      j8_q   <= jd_w;
      deg8_q <= degd_w;
      for (int i = 0; i < 3; i++) begin
        kt8_q[i]  <= K_THIRD * td_w[i];
        k2m8_q[i] <= K_2R2_3 * quo[i];
        km8_q[i]  <= K_R2_3 * quo[i];
        kr8_q[i]  <= K_R23 * quo[3+i];
      end
    end
  end

  // S9: offset sums in Q28
  logic v9_q, deg9_q;
  logic signed [DW-1:0] s9_q [3], d9_q [3];
  logic [JW-1:0]        j9_q;
  logic signed [NW-1:0] vq9_q [3], uq9_q [3], wq9_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s9_q   <= s8_q;
      d9_q   <= d8_q;
      j9_q   <= j8_q;
      deg9_q <= deg8_q;
      for (int i = 0; i < 3; i++) begin
        vq9_q[i] <= NW'(kt8_q[i]) - NW'(k2m8_q[i]);
        uq9_q[i] <= NW'(kt8_q[i]) + NW'(km8_q[i]) + NW'(kr8_q[i]);
        wq9_q[i] <= NW'(kr8_q[i]) - NW'(kt8_q[i]) - NW'(km8_q[i]);
      end
    end
  end

  // S10: back to half-LSB units, rounding half up
  logic v10_q, deg10_q;
  logic signed [DW-1:0] s10_q [3], d10_q [3];
  logic signed [OW-1:0] ov10_q [3], ou10_q [3], ow10_q [3];
  logic signed [NW-1:0] rnd, rv [3], ru [3], rw [3];

  always_comb begin
    rnd = NW'(1) <<< (j9_q - JW'(1));
    for (int i = 0; i < 3; i++) begin
      rv[i] = (vq9_q[i] + rnd) >>> j9_q;
      ru[i] = (uq9_q[i] + rnd) >>> j9_q;
      rw[i] = (wq9_q[i] + rnd) >>> j9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s10_q   <= s9_q;
      d10_q   <= d9_q;
      deg10_q <= deg9_q;
      for (int i = 0; i < 3; i++) begin
        ov10_q[i] <= deg9_q ? '0 : rv[i][OW-1:0];
        ou10_q[i] <= deg9_q ? '0 : ru[i][OW-1:0];
        ow10_q[i] <= deg9_q ? '0 : rw[i][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else if (en) begin
      v1_q  <= diag_i.valid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
      v6_q  <= v5_q;
      v7_q  <= vs_o;
      v8_q  <= vd_o;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  // pipeline moves whenever its last stage is empty or being handed over
  assign en = !v10_q || take;

  cvd_emit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v10_q),
    .sum_i   (s10_q),
    .dif_i   (d10_q),
    .ov_i    (ov10_q),
    .ou_i    (ou10_q),
    .ow_i    (ow10_q),
    .deg_i   (deg10_q),
    .take_o  (take),
    .vert_o  (vert_o)
  );

endmodule

`default_nettype wire

@@ src/cvd_checker.sv @@
// ----------------------------------------------------------------------------
// cvd_checker
// Port-level checks on the corner stream of the cube vertex unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cvd_checker #(
  parameter int unsigned COORD_WIDTH = cvd_pkg::CVD_COORD_WIDTH
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [2:0]             index_i,
  input logic [COORD_WIDTH-1:0] x_i,
  input logic                   last_i,
  input logic                   deg_i
);

  logic xfer;
  assign xfer = out_valid_i && out_ready_i;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(index_i) && $stable(x_i))
    else $error("corner changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (index_i == 3'd7)))
    else $error("last mark not on corner seven");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !last_i |=> out_valid_i && index_i == $past(index_i) + 3'd1
                        && deg_i == $past(deg_i))
    else $error("corner run broken");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && last_i |=> !out_valid_i || index_i == 3'd0)
    else $error("run does not start at corner zero");

endmodule

bind cube_vertices_from_diagonal_unit cvd_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_cvd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (vert_o.valid),
  .out_ready_i (vert_o.ready),
  .index_i     (vert_o.vertex_index),
  .x_i         (vert_o.vertex_x),
  .last_i      (vert_o.last_vertex),
  .deg_i       (vert_o.degenerate)
);

`default_nettype wire

@@ dv/cube_vertices_from_diagonal_unit_test.sv @@
// ----------------------------------------------------------------------------
// cube_vertices_from_diagonal_unit_test
// Drives diagonals into the cube vertex unit and checks every corner transfer
// against a fixed point predictor of the cube geometry, with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cube_vertices_from_diagonal_unit_test;
  import cvd_pkg::*;

  localparam int CW = CVD_COORD_WIDTH;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 265;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, az, bx, by, bz;
  } diag_t;

  typedef struct {
    vtx_e   idx;
    coord_t x, y, z;
    logic   last, degen;
  } corner_t;

  // directed row: expected center typed in only for equal-end rows
  typedef struct {
    diag_t  d;
    logic   chk_center;
    coord_t cx, cy, cz;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  cvd_in_if  diag_if ();
  cvd_out_if vert_if ();

  cube_vertices_from_diagonal_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .diag_i (diag_if.sink),
    .vert_o (vert_if.source)
  );

  corner_t expected_corners[$];
  int      n_errors = 0;
  int      idle_cycles = 0;
  bit      stim_done = 1'b0;

  function automatic longint unsigned abs64(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint floor_shr(longint x, int k);
    if (x >= 0) return x >>> k;
    return -longint'((abs64(x) + ((64'd1 << k) - 1)) >> k);
  endfunction

  function automatic longint round_shr(longint x, int k);
    return floor_shr(x + (longint'(1) << (k - 1)), k);
  endfunction

  function automatic longint div_round(longint n, longint den);
    longint unsigned q;
    q = (abs64(n) + longint'(den) / 2) / den;
    return n < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sqrt_round(longint unsigned x);
    longint unsigned rem, res, b;
    rem = x; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    if (x - res * res > res) res++;
    return res;
  endfunction

  function automatic coord_t clamp_coord(longint x);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? coord_t'(hi) : (x < lo ? coord_t'(lo) : coord_t'(x));
  endfunction

  task automatic predict_corners(diag_t dg);
    longint s[3], d[3], t[3], q[3], m[3], rn[3], off[8][3];
    longint r2, q2, qn, r, x2, y2, z2, vq, uq, wq, ov, ou, ow;
    longint unsigned mx;
    int sh, j, e;
    logic degen;
    corner_t c;
    s[0] = longint'(dg.ax) + dg.bx; d[0] = longint'(dg.ax) - dg.bx;
    s[1] = longint'(dg.ay) + dg.by; d[1] = longint'(dg.ay) - dg.by;
    s[2] = longint'(dg.az) + dg.bz; d[2] = longint'(dg.az) - dg.bz;
    mx = 0;
    for (int i = 0; i < 3; i++) if (abs64(d[i]) > mx) mx = abs64(d[i]);
    degen = (mx == 0);
    for (int k = 0; k < 8; k++) for (int i = 0; i < 3; i++) off[k][i] = 0;
    if (!degen) begin
      sh = 0;
      if (mx >= (64'd1 << (NORM_LO + 1))) begin
        while ((mx >> sh) >= (64'd1 << (NORM_LO + 1))) sh++;
        for (int i = 0; i < 3; i++)
          t[i] = d[i] < 0 ? -longint'(abs64(d[i]) >> sh) : longint'(abs64(d[i]) >> sh);
        j = KQ - sh;
      end else begin
        while ((mx << sh) < (64'd1 << NORM_LO)) sh++;
        for (int i = 0; i < 3; i++) t[i] = d[i] * (longint'(1) << sh);
        j = KQ + sh;
      end
      x2 = t[0] * t[0]; y2 = t[1] * t[1]; z2 = t[2] * t[2];
      r2 = x2 + y2 + z2;
      // helper axis is y when u leans strongly along x
      if (7 * x2 > 9 * (y2 + z2)) begin
        e = 1; q[0] = -t[2]; q[1] = 0; q[2] = t[0]; q2 = x2 + z2;
      end else begin
        e = 0; q[0] = 0; q[1] = t[2]; q[2] = -t[1]; q2 = y2 + z2;
      end
      qn = sqrt_round(q2);
      r = sqrt_round(r2);
      if (qn < 1) qn = 1;
      for (int i = 0; i < 3; i++) begin
        m[i] = div_round((i == e ? r2 : 0) - t[e] * t[i], qn);
        rn[i] = div_round(r * q[i], qn);
      end
      for (int i = 0; i < 3; i++) begin
        vq = longint'(K_THIRD) * t[i] - longint'(K_2R2_3) * m[i];
        uq = longint'(K_THIRD) * t[i] + longint'(K_R2_3) * m[i] + longint'(K_R23) * rn[i];
        wq = -longint'(K_THIRD) * t[i] - longint'(K_R2_3) * m[i] + longint'(K_R23) * rn[i];
        ov = round_shr(vq, j); ou = round_shr(uq, j); ow = round_shr(wq, j);
        off[VTX_PU][i] = d[i];  off[VTX_MU][i] = -d[i];
        off[VTX_PV][i] = ov;    off[VTX_MV][i] = -ov;
        off[VTX_PUU][i] = ou;   off[VTX_MUU][i] = -ou;
        off[VTX_PVV][i] = ow;   off[VTX_MVV][i] = -ow;
      end
    end
    for (int k = 0; k < 8; k++) begin
      c.idx = vtx_e'(k);
      c.x = clamp_coord(floor_shr(s[0] + off[k][0] + 1, 1));
      c.y = clamp_coord(floor_shr(s[1] + off[k][1] + 1, 1));
      c.z = clamp_coord(floor_shr(s[2] + off[k][2] + 1, 1));
      c.last = (vtx_e'(k) == VTX_MV);
      c.degen = degen;
      expected_corners.push_back(c);
    end
  endtask

  // called at a falling edge; valid stays high into the next item when no gap
  task automatic send_diag(diag_t dg);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      diag_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    diag_if.valid <= 1'b1;
    diag_if.corner_a_x <= dg.ax; diag_if.corner_a_y <= dg.ay;
    diag_if.corner_a_z <= dg.az; diag_if.corner_b_x <= dg.bx;
    diag_if.corner_b_y <= dg.by; diag_if.corner_b_z <= dg.bz;
    do @(posedge clk_i); while (!diag_if.ready);
    predict_corners(dg);
    @(negedge clk_i);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return coord_t'($signed($urandom) >>> $urandom_range(4, 28));
    endcase
  endfunction

  // receiver: random stall per corner
  initial begin
    int gap;
    vert_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        vert_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      vert_if.ready <= 1'b1;
      do @(posedge clk_i); while (!vert_if.valid);
    end
  end

  // corner checker
  always @(posedge clk_i) begin
    if (rst_ni && vert_if.valid && vert_if.ready) begin
      if (expected_corners.size() == 0) begin
        $error("unexpected corner transfer index %0d", vert_if.vertex_index);
        n_errors++;
      end else begin
        corner_t c;
        c = expected_corners.pop_front();
        if (vert_if.vertex_index !== c.idx) begin
          $error("vertex_index exp %0d got %0d", c.idx, vert_if.vertex_index); n_errors++;
        end
        if (vert_if.vertex_x !== c.x) begin
          $error("vertex_x exp %0d got %0d", c.x, vert_if.vertex_x); n_errors++;
        end
        if (vert_if.vertex_y !== c.y) begin
          $error("vertex_y exp %0d got %0d", c.y, vert_if.vertex_y); n_errors++;
        end
        if (vert_if.vertex_z !== c.z) begin
          $error("vertex_z exp %0d got %0d", c.z, vert_if.vertex_z); n_errors++;
        end
        if (vert_if.last_vertex !== c.last) begin
          $error("last_vertex exp %0b got %0b", c.last, vert_if.last_vertex); n_errors++;
        end
        if (vert_if.degenerate !== c.degen) begin
          $error("degenerate exp %0b got %0b", c.degen, vert_if.degenerate); n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((diag_if.valid && diag_if.ready) || (vert_if.valid && vert_if.ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("cube_vertices_from_diagonal_unit test failed");
        $finish;
      end
    end
  end

  row_t rows[$];

  task automatic add_row(coord_t ax, ay, az, bx, by, bz, logic chk,
                         coord_t cx = 0, coord_t cy = 0, coord_t cz = 0);
    row_t rw;
    rw.d = '{ax, ay, az, bx, by, bz};
    rw.chk_center = chk; rw.cx = cx; rw.cy = cy; rw.cz = cz;
    rows.push_back(rw);
  endtask

  initial begin
    diag_t dg;
    corner_t c;
    int first;
    diag_if.valid = 1'b0;
    diag_if.corner_a_x = '0; diag_if.corner_a_y = '0; diag_if.corner_a_z = '0;
    diag_if.corner_b_x = '0; diag_if.corner_b_y = '0; diag_if.corner_b_z = '0;

    // equal ends: every corner is the point itself
    add_row(0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0);
    add_row(32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000,
            32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 1'b1,
            32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000);
    add_row(-1, -1, -1, -1, -1, -1, 1'b1, -1, -1, -1);
    // unit cube diagonal, axis choices, tiny and huge diagonals
    add_row(32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 0, 1'b0);
    add_row(32'sh10000, 0, 0, 0, 0, 0, 1'b0);
    add_row(0, 32'sh10000, 0, 0, 0, 0, 1'b0);
    add_row(0, 0, 32'sh10000, 0, 0, 0, 1'b0);
    add_row(32'sh30000, 32'sh10000, 0, 0, 0, 0, 1'b0);
    add_row(1, 0, 0, 0, 0, 0, 1'b0);
    add_row(0, 0, 0, 1, 1, 1, 1'b0);
    add_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    add_row(32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 1'b0);
    add_row(32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0, 0, 1'b0);
    add_row(32'sh7FFF0000, 32'sh7FFF0000, 32'sh7FFF0000,
            32'sh7FFE0000, 32'sh7FFE0000, 32'sh7FFE0000, 1'b0);
    add_row(-32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000, -32'sh50000, 32'sh60000, 1'b0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      first = expected_corners.size();
      send_diag(rows[i].d);
      if (rows[i].chk_center) begin
        // typed-in expectation replaces the predicted one for equal ends
        for (int k = first; k < expected_corners.size(); k++) begin
          c = expected_corners[k];
          c.x = rows[i].cx; c.y = rows[i].cy; c.z = rows[i].cz; c.degen = 1'b1;
          expected_corners[k] = c;
        end
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      dg.ax = rand_coord(); dg.ay = rand_coord(); dg.az = rand_coord();
      case ($urandom_range(0, 9))
        0: begin dg.bx = dg.ax; dg.by = dg.ay; dg.bz = dg.az; end
        1: begin
          dg.bx = dg.ax + $signed($urandom_range(0, 4)) - 2;
          dg.by = dg.ay + $signed($urandom_range(0, 4)) - 2;
          dg.bz = dg.az + $signed($urandom_range(0, 4)) - 2;
        end
        default: begin dg.bx = rand_coord(); dg.by = rand_coord(); dg.bz = rand_coord(); end
      endcase
      send_diag(dg);
    end
    diag_if.valid <= 1'b0;

    while (expected_corners.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0 && expected_corners.size() == 0)
      $display("cube_vertices_from_diagonal_unit test passed");
    else
      $display("cube_vertices_from_diagonal_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/cvd_pkg.sv
src/cvd_if.sv
src/cvd_isqrt.sv
src/cvd_div.sv
src/cvd_emit.sv
src/cube_vertices_from_diagonal_unit.sv
src/cvd_checker.sv
dv/cube_vertices_from_diagonal_unit_test.sv
